### hw/rtl/lobm_pkg.sv
`default_nettype none
package lobm_pkg;

  localparam int LOBM_BOOK_DEPTH = 32;

  // Request kinds.
  localparam logic [1:0] KIND_SUBMIT = 2'd0;
  localparam logic [1:0] KIND_CANCEL = 2'd1;
  localparam logic [1:0] KIND_MODIFY = 2'd2;

  // Order types.
  localparam logic [1:0] TYPE_LIMIT  = 2'd0;
  localparam logic [1:0] TYPE_MARKET = 2'd1;
  localparam logic [1:0] TYPE_IOC    = 2'd2;
  localparam logic [1:0] TYPE_FOK    = 2'd3;

  // Final status codes.
  localparam logic [2:0] ST_RESTED     = 3'd0;
  localparam logic [2:0] ST_FILLED     = 3'd1;
  localparam logic [2:0] ST_DROPPED    = 3'd2;
  localparam logic [2:0] ST_KILLED     = 3'd3;
  localparam logic [2:0] ST_CANCELLED  = 3'd4;
  localparam logic [2:0] ST_CANCEL_REJ = 3'd5;
  localparam logic [2:0] ST_MODIFY_REJ = 3'd6;
  localparam logic [2:0] ST_BOOK_FULL  = 3'd7;

  // Result kinds.
  localparam logic RK_TRADE  = 1'b0;
  localparam logic RK_STATUS = 1'b1;

  // Command broadcast to every cell of one book.
  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_WRITE,
    CMD_FILL,
    CMD_CLEAR
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [31:0] id;
    logic [23:0] level;
    logic [31:0] qty;
    logic [31:0] arrival;
  } cell_cmd_t;

  // Search key shared by all cells during a scan.
  typedef struct packed {
    logic [23:0] price;
    logic [31:0] match_id;
  } scan_key_t;

  // Scan result handed from cell to cell.
  typedef struct packed {
    logic        best_found;
    logic [23:0] best_level;
    logic [31:0] best_arrival;
    logic [31:0] best_id;
    logic [31:0] best_qty;
    logic [63:0] sum;
    logic        free_found;
    logic        match_found;
    logic [31:0] match_qty;
  } scan_carry_t;

endpackage
`default_nettype wire

### hw/rtl/limit_order_book_matcher.sv
// Each request scans the cell rows and then acts on the result in a decision step.
// A request with T trades needs T+1 scans, and a modify adds one more scan.
// One request is in work at a time.
// The scan length is set by the result travelling one cell per cycle along each row.
// Reset (rst_n low, synchronous) empties both books and sets the counters to their start values.
`default_nettype none
module limit_order_book_matcher #(
  parameter int BOOK_DEPTH = lobm_pkg::LOBM_BOOK_DEPTH
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  // order_id[31:0], side[32], order_type[34:33], price[58:35], qty[90:59], zero fill
  input  wire  [95:0]  in_tdata,
  // kind[1:0]
  input  wire  [1:0]   in_tuser,
  output logic         out_tvalid,
  input  wire          out_tready,
  // status[2:0], subject_order_id[34:3], buyer_id[66:35], seller_id[98:67],
  // trade_price[122:99], trade_qty[154:123], trade_number[186:155],
  // left_qty[218:187], zero fill
  output logic [223:0] out_tdata,
  // result_kind[0]
  output logic         out_tuser,
  output logic         out_tlast
);
  import lobm_pkg::*;

  localparam int IDX_W = $clog2(BOOK_DEPTH);
  localparam int CNT_W = $clog2(BOOK_DEPTH);
  localparam int ITER_W = $clog2(BOOK_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } state_t;

  state_t            state_r, state_nxt;
  logic [1:0]        kind_r, kind_nxt;
  logic [31:0]       id_r, id_nxt;
  logic              side_r, side_nxt;
  logic [1:0]        type_r, type_nxt;
  logic [23:0]       price_r, price_nxt;
  logic [31:0]       rem_r, rem_nxt;
  logic              first_r, first_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [31:0]       trade_cnt_r, trade_cnt_nxt;
  logic [31:0]       arrival_r, arrival_nxt;
  logic [31:0]       new_id_r, new_id_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_rk_r, out_rk_nxt;
  logic [2:0]        out_status_r, out_status_nxt;
  logic [31:0]       out_subj_r, out_subj_nxt;
  logic [31:0]       out_buyer_r, out_buyer_nxt;
  logic [31:0]       out_seller_r, out_seller_nxt;
  logic [23:0]       out_tp_r, out_tp_nxt;
  logic [31:0]       out_tq_r, out_tq_nxt;
  logic [31:0]       out_tn_r, out_tn_nxt;
  logic [31:0]       out_left_r, out_left_nxt;
  logic              out_last_r, out_last_nxt;

  cell_cmd_t        bid_cmd, ask_cmd;
  logic [IDX_W-1:0] bid_cmd_idx, ask_cmd_idx;
  scan_key_t        key;
  scan_carry_t      bid_res, ask_res, opp_res, own_res;
  logic [IDX_W-1:0] bid_best, bid_free, bid_match;
  logic [IDX_W-1:0] ask_best, ask_free, ask_match;
  logic [IDX_W-1:0] opp_best, own_free;

  logic        out_free;
  logic        in_fire;
  logic        emit_trade;
  logic        acc;
  logic [31:0] tq;

  assign key = '{price: price_r, match_id: id_r};

  lobm_book #(.BOOK_DEPTH(BOOK_DEPTH), .IDX_W(IDX_W), .ASK(1'b0)) u_bid (
    .clk (clk), .rst_n (rst_n), .cmd (bid_cmd), .cmd_idx (bid_cmd_idx), .key (key),
    .result (bid_res), .best_idx (bid_best), .free_idx (bid_free), .match_idx (bid_match)
  );

  lobm_book #(.BOOK_DEPTH(BOOK_DEPTH), .IDX_W(IDX_W), .ASK(1'b1)) u_ask (
    .clk (clk), .rst_n (rst_n), .cmd (ask_cmd), .cmd_idx (ask_cmd_idx), .key (key),
    .result (ask_res), .best_idx (ask_best), .free_idx (ask_free), .match_idx (ask_match)
  );

  assign opp_res  = side_r ? bid_res : ask_res;
  assign own_res  = side_r ? ask_res : bid_res;
  assign opp_best = side_r ? bid_best : ask_best;
  assign own_free = side_r ? ask_free : bid_free;
  assign acc = side_r ? (opp_res.best_level >= price_r) : (opp_res.best_level <= price_r);
  assign tq  = (rem_r < opp_res.best_qty) ? rem_r : opp_res.best_qty;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // Request sequencer: scan the rows, then act on the scan result.
  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    id_nxt        = id_r;
    side_nxt      = side_r;
    type_nxt      = type_r;
    price_nxt     = price_r;
    rem_nxt       = rem_r;
    first_nxt     = first_r;
    iter_nxt      = iter_r;
    cnt_nxt       = cnt_r;
    trade_cnt_nxt = trade_cnt_r;
    arrival_nxt   = arrival_r;
    new_id_nxt    = new_id_r;
    emit_trade    = 1'b0;

    out_valid_nxt  = out_tready ? 1'b0 : out_valid_r;
    out_rk_nxt     = out_rk_r;
    out_status_nxt = out_status_r;
    out_subj_nxt   = out_subj_r;
    out_buyer_nxt  = out_buyer_r;
    out_seller_nxt = out_seller_r;
    out_tp_nxt     = out_tp_r;
    out_tq_nxt     = out_tq_r;
    out_tn_nxt     = out_tn_r;
    out_left_nxt   = out_left_r;
    out_last_nxt   = out_last_r;

    bid_cmd     = '0;
    ask_cmd     = '0;
    bid_cmd.op  = CMD_NOP;
    ask_cmd.op  = CMD_NOP;
    bid_cmd_idx = '0;
    ask_cmd_idx = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          kind_nxt  = in_tuser;
          id_nxt    = in_tdata[31:0];
          side_nxt  = in_tdata[32];
          type_nxt  = in_tdata[34:33];
          price_nxt = in_tdata[58:35];
          rem_nxt   = in_tdata[90:59];
          first_nxt = 1'b1;
          iter_nxt  = '0;
          cnt_nxt   = '0;
          if (in_tuser == KIND_SUBMIT || in_tuser == KIND_CANCEL ||
              in_tuser == KIND_MODIFY) begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (cnt_r == CNT_W'(BOOK_DEPTH - 1)) begin
          state_nxt = S_DECIDE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DECIDE: begin
        if (out_free) begin
          // Every status defaults to a zeroed trade part.
          out_rk_nxt     = RK_STATUS;
          out_subj_nxt   = id_r;
          out_buyer_nxt  = '0;
          out_seller_nxt = '0;
          out_tp_nxt     = '0;
          out_tq_nxt     = '0;
          out_tn_nxt     = '0;
          out_left_nxt   = '0;
          out_last_nxt   = 1'b1;
          cnt_nxt        = '0;
          if (kind_r == KIND_CANCEL) begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
            if (bid_res.match_found) begin
              bid_cmd.op     = CMD_CLEAR;
              bid_cmd_idx    = bid_match;
              out_status_nxt = ST_CANCELLED;
              out_left_nxt   = bid_res.match_qty;
            end else if (ask_res.match_found) begin
              ask_cmd.op     = CMD_CLEAR;
              ask_cmd_idx    = ask_match;
              out_status_nxt = ST_CANCELLED;
              out_left_nxt   = ask_res.match_qty;
            end else begin
              out_status_nxt = ST_CANCEL_REJ;
            end
          end else if (kind_r == KIND_MODIFY) begin
            if (bid_res.match_found || ask_res.match_found) begin
              // Pull the old order, then rescan and run it as a fresh limit order.
              if (bid_res.match_found) begin
                bid_cmd.op  = CMD_CLEAR;
                bid_cmd_idx = bid_match;
                side_nxt    = 1'b0;
              end else begin
                ask_cmd.op  = CMD_CLEAR;
                ask_cmd_idx = ask_match;
                side_nxt    = 1'b1;
              end
              id_nxt     = new_id_r;
              new_id_nxt = new_id_r + 32'd1;
              type_nxt   = TYPE_LIMIT;
              kind_nxt   = KIND_SUBMIT;
              state_nxt  = S_SCAN;
            end else begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_MODIFY_REJ;
              state_nxt      = S_IDLE;
            end
          end else begin
            if (first_r && type_r == TYPE_FOK && opp_res.sum < {32'd0, rem_r}) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_KILLED;
              out_left_nxt   = rem_r;
              state_nxt      = S_IDLE;
            end else if (rem_r != 32'd0 && iter_r != ITER_W'(BOOK_DEPTH) &&
                         opp_res.best_found && (type_r == TYPE_MARKET || acc)) begin
              // One fill against the best resting order, then rescan.
              emit_trade     = 1'b1;
              out_valid_nxt  = 1'b1;
              out_rk_nxt     = RK_TRADE;
              out_status_nxt = ST_RESTED;
              out_buyer_nxt  = side_r ? opp_res.best_id : id_r;
              out_seller_nxt = side_r ? id_r : opp_res.best_id;
              out_tp_nxt     = opp_res.best_level;
              out_tq_nxt     = tq;
              out_tn_nxt     = trade_cnt_r;
              out_last_nxt   = 1'b0;
              trade_cnt_nxt  = trade_cnt_r + 32'd1;
              rem_nxt        = rem_r - tq;
              iter_nxt       = iter_r + 1'b1;
              first_nxt      = 1'b0;
              state_nxt      = S_SCAN;
              if (side_r) begin
                bid_cmd.op  = CMD_FILL;
                bid_cmd.qty = tq;
                bid_cmd_idx = opp_best;
              end else begin
                ask_cmd.op  = CMD_FILL;
                ask_cmd.qty = tq;
                ask_cmd_idx = opp_best;
              end
            end else begin
              out_valid_nxt = 1'b1;
              out_left_nxt  = rem_r;
              state_nxt     = S_IDLE;
              if (rem_r == 32'd0) begin
                out_status_nxt = ST_FILLED;
              end else if (type_r == TYPE_LIMIT) begin
                if (own_res.free_found) begin
                  out_status_nxt = ST_RESTED;
                  arrival_nxt    = arrival_r + 32'd1;
                  if (side_r) begin
                    ask_cmd     = '{CMD_WRITE, id_r, price_r, rem_r, arrival_r};
                    ask_cmd_idx = own_free;
                  end else begin
                    bid_cmd     = '{CMD_WRITE, id_r, price_r, rem_r, arrival_r};
                    bid_cmd_idx = own_free;
                  end
                end else begin
                  out_status_nxt = ST_BOOK_FULL;
                end
              end else begin
                out_status_nxt = ST_DROPPED;
              end
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      trade_cnt_r <= 32'd1;
      arrival_r   <= 32'd0;
      new_id_r    <= 32'd1;
      cnt_r       <= '0;
      iter_r      <= '0;
      first_r     <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      trade_cnt_r <= trade_cnt_nxt;
      arrival_r   <= arrival_nxt;
      new_id_r    <= new_id_nxt;
      cnt_r       <= cnt_nxt;
      iter_r      <= iter_nxt;
      first_r     <= first_nxt;
    end
    kind_r       <= kind_nxt;
    id_r         <= id_nxt;
    side_r       <= side_nxt;
    type_r       <= type_nxt;
    price_r      <= price_nxt;
    rem_r        <= rem_nxt;
    out_rk_r     <= out_rk_nxt;
    out_status_r <= out_status_nxt;
    out_subj_r   <= out_subj_nxt;
    out_buyer_r  <= out_buyer_nxt;
    out_seller_r <= out_seller_nxt;
    out_tp_r     <= out_tp_nxt;
    out_tq_r     <= out_tq_nxt;
    out_tn_r     <= out_tn_nxt;
    out_left_r   <= out_left_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_rk_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {5'd0, out_left_r, out_tn_r, out_tq_r, out_tp_r,
                       out_seller_r, out_buyer_r, out_subj_r, out_status_r};

`ifndef ASSERT_OFF
  // A trade report never closes a request.
  a_trade_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == RK_TRADE |-> !out_tlast)
    else $error("trade report marked last");

  // Each trade advances the running trade number by one.
  a_trade_count: assert property (@(posedge clk) disable iff (!rst_n)
    emit_trade |=> trade_cnt_r == $past(trade_cnt_r) + 32'd1)
    else $error("trade number did not advance");

  // No new request is taken while one is in work.
  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_tready)
    else $error("input ready while busy");
`endif

endmodule
`default_nettype wire

### hw/rtl/lobm_cell.sv
`default_nettype none
module lobm_cell #(
  parameter int IDX_W = 5,
  parameter int IDX   = 0,
  parameter bit ASK   = 1'b0
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  lobm_pkg::cell_cmd_t      cmd,
  input  wire  [IDX_W-1:0]         cmd_idx,
  input  lobm_pkg::scan_key_t      key,
  input  lobm_pkg::scan_carry_t    carry_i,
  input  wire  [IDX_W-1:0]         best_idx_i,
  input  wire  [IDX_W-1:0]         free_idx_i,
  input  wire  [IDX_W-1:0]         match_idx_i,
  output lobm_pkg::scan_carry_t    carry_o,
  output logic [IDX_W-1:0]         best_idx_o,
  output logic [IDX_W-1:0]         free_idx_o,
  output logic [IDX_W-1:0]         match_idx_o
);
  import lobm_pkg::*;

  logic        valid_r, valid_nxt;
  logic [31:0] id_r, id_nxt;
  logic [23:0] level_r, level_nxt;
  logic [31:0] qty_r, qty_nxt;
  logic [31:0] arrival_r, arrival_nxt;
  scan_carry_t carry_r, carry_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic [IDX_W-1:0] match_idx_r, match_idx_nxt;
  logic        hit;
  logic        better;
  logic        accept;
  logic [31:0] fill_left;

  assign hit       = (cmd_idx == IDX_W'(IDX));
  assign fill_left = qty_r - cmd.qty;

  // Entry update from the broadcast command.
  always_comb begin
    valid_nxt   = valid_r;
    id_nxt      = id_r;
    level_nxt   = level_r;
    qty_nxt     = qty_r;
    arrival_nxt = arrival_r;
    if (hit) begin
      unique case (cmd.op)
        CMD_WRITE: begin
          valid_nxt   = 1'b1;
          id_nxt      = cmd.id;
          level_nxt   = cmd.level;
          qty_nxt     = cmd.qty;
          arrival_nxt = cmd.arrival;
        end
        CMD_FILL: begin
          qty_nxt = fill_left;
          if (fill_left == 32'd0) valid_nxt = 1'b0;
        end
        CMD_CLEAR: valid_nxt = 1'b0;
        default: ;
      endcase
    end
  end

  // Merge this entry into the scan result coming from the lower cells.
  always_comb begin
    if (carry_i.best_level != level_r) begin
      better = ASK ? (level_r < carry_i.best_level) : (level_r > carry_i.best_level);
    end else begin
      better = arrival_r < carry_i.best_arrival;
    end
    accept = ASK ? (level_r <= key.price) : (level_r >= key.price);

    carry_nxt     = carry_i;
    best_idx_nxt  = best_idx_i;
    free_idx_nxt  = free_idx_i;
    match_idx_nxt = match_idx_i;
    if (valid_r) begin
      if (!carry_i.best_found || better) begin
        carry_nxt.best_found   = 1'b1;
        carry_nxt.best_level   = level_r;
        carry_nxt.best_arrival = arrival_r;
        carry_nxt.best_id      = id_r;
        carry_nxt.best_qty     = qty_r;
        best_idx_nxt           = IDX_W'(IDX);
      end
      if (accept) carry_nxt.sum = carry_i.sum + {32'd0, qty_r};
      if (!carry_i.match_found && id_r == key.match_id) begin
        carry_nxt.match_found = 1'b1;
        carry_nxt.match_qty   = qty_r;
        match_idx_nxt         = IDX_W'(IDX);
      end
    end else if (!carry_i.free_found) begin
      carry_nxt.free_found = 1'b1;
      free_idx_nxt         = IDX_W'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    id_r        <= id_nxt;
    level_r     <= level_nxt;
    qty_r       <= qty_nxt;
    arrival_r   <= arrival_nxt;
    carry_r     <= carry_nxt;
    best_idx_r  <= best_idx_nxt;
    free_idx_r  <= free_idx_nxt;
    match_idx_r <= match_idx_nxt;
  end

  assign carry_o     = carry_r;
  assign best_idx_o  = best_idx_r;
  assign free_idx_o  = free_idx_r;
  assign match_idx_o = match_idx_r;

endmodule
`default_nettype wire

### hw/rtl/lobm_book.sv
`default_nettype none
module lobm_book #(
  parameter int BOOK_DEPTH = 32,
  parameter int IDX_W      = 5,
  parameter bit ASK        = 1'b0
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  lobm_pkg::cell_cmd_t      cmd,
  input  wire  [IDX_W-1:0]         cmd_idx,
  input  lobm_pkg::scan_key_t      key,
  output lobm_pkg::scan_carry_t    result,
  output logic [IDX_W-1:0]         best_idx,
  output logic [IDX_W-1:0]         free_idx,
  output logic [IDX_W-1:0]         match_idx
);
  import lobm_pkg::*;

  scan_carry_t      carry_w [BOOK_DEPTH+1];
  logic [IDX_W-1:0] best_w  [BOOK_DEPTH+1];
  logic [IDX_W-1:0] free_w  [BOOK_DEPTH+1];
  logic [IDX_W-1:0] match_w [BOOK_DEPTH+1];

  // The scan enters the row empty at the lowest slot.
  assign carry_w[0] = '0;
  assign best_w[0]  = '0;
  assign free_w[0]  = '0;
  assign match_w[0] = '0;

  for (genvar g = 0; g < BOOK_DEPTH; g++) begin : g_cell
    lobm_cell #(.IDX_W(IDX_W), .IDX(g), .ASK(ASK)) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .cmd_idx     (cmd_idx),
      .key         (key),
      .carry_i     (carry_w[g]),
      .best_idx_i  (best_w[g]),
      .free_idx_i  (free_w[g]),
      .match_idx_i (match_w[g]),
      .carry_o     (carry_w[g+1]),
      .best_idx_o  (best_w[g+1]),
      .free_idx_o  (free_w[g+1]),
      .match_idx_o (match_w[g+1])
    );
  end

  assign result    = carry_w[BOOK_DEPTH];
  assign best_idx  = best_w[BOOK_DEPTH];
  assign free_idx  = free_w[BOOK_DEPTH];
  assign match_idx = match_w[BOOK_DEPTH];

endmodule
`default_nettype wire
